// ----- rtl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// Line pixel stepper package
// Shared constants, register indexes and request codes for the rasterizer.
// ----------------------------------------------------------------------------
package lps_pkg;

  parameter int unsigned COORD_BITS_DEF = 12;
  parameter int unsigned COLOR_BITS_DEF = 32;

  parameter int unsigned FRAME_WIDTH_RESET  = 240;
  parameter int unsigned FRAME_HEIGHT_RESET = 320;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

endpackage

// ----- rtl/line_pixel_stepper.sv -----
// ----------------------------------------------------------------------------
// Line pixel stepper
// Bresenham line rasterizer with frame clipping and linear address output.
// ----------------------------------------------------------------------------
// A begin request loads both endpoints and the color and yields the first
// pixel; each step request yields the next pixel along the line. The block
// takes one request per clock while the output side is not stalled and returns
// one result per request, registered in both stages. The first stage holds
// the line state and does the error update, one add and one compare per pixel;
// the second stage does the frame clipping and the row stride multiply that
// forms the address. A step after the end pixel returns a result with the
// write flag cleared and last set. Frame registers may only be written while
// no request is in flight.
module line_pixel_stepper #(
  parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = lps_pkg::COLOR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_write_i,
  input  lps_pkg::reg_idx_e            cfg_index_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lps_pkg::op_e                 opcode_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0]        line_color_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         write_enable_o,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic [2*COORD_BITS-3:0]      pixel_address_o,
  output logic [COLOR_BITS-1:0]        pixel_color_o,
  output logic                         last_o
);
  import lps_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned AW = 2 * COORD_BITS - 2;
  localparam int unsigned EW = COORD_BITS + 3;

  // Configuration registers.
  logic [C-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= C'(FRAME_WIDTH_RESET);
      frame_height_q <= C'(FRAME_HEIGHT_RESET);
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake across the two stages.
  logic s1_valid_q, out_valid_q;
  logic s1_ready, s2_ready, in_accept;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_accept  = in_valid_i && s1_ready;

  // Line state: the last emitted pixel and the pixels still to come.
  logic signed [C-1:0] cur_x_q, cur_y_q;
  logic                x_neg_q, y_neg_q, y_major_q;
  logic [C:0]          two_minor_q, two_major_q;
  logic signed [EW-1:0] err_q;
  logic [C-1:0]        remain_q;
  logic [COLOR_BITS-1:0] color_q;

  // Begin path.
  logic signed [C:0] dx, dy;
  logic [C:0]        dx_abs, dy_abs;
  logic [C-1:0]      span_x, span_y, span_major, span_minor;
  logic              begin_y_major;

  always_comb begin
    dx            = {end_x_i[C-1], end_x_i} - {start_x_i[C-1], start_x_i};
    dy            = {end_y_i[C-1], end_y_i} - {start_y_i[C-1], start_y_i};
    dx_abs        = dx[C] ? -dx : dx;
    dy_abs        = dy[C] ? -dy : dy;
    span_x        = dx_abs[C-1:0];
    span_y        = dy_abs[C-1:0];
    begin_y_major = span_y > span_x;
    span_major    = begin_y_major ? span_y : span_x;
    span_minor    = begin_y_major ? span_x : span_y;
  end

  // Step path.
  logic signed [EW-1:0] err_add, err_next;
  logic                 move_minor, move_x, move_y;
  logic [C-1:0]         step_x, step_y;
  logic signed [C-1:0]  next_x, next_y;
  logic                 line_active;

  always_comb begin
    line_active = remain_q != '0;
    err_add     = err_q + EW'(two_minor_q);
    move_minor  = !err_add[EW-1] && (err_add != '0);
    err_next    = move_minor ? err_add - EW'(two_major_q) : err_add;
    move_x      = y_major_q ? move_minor : 1'b1;
    move_y      = y_major_q ? 1'b1 : move_minor;
    step_x      = x_neg_q ? '1 : C'(1);
    step_y      = y_neg_q ? '1 : C'(1);
    next_x      = cur_x_q + (move_x ? step_x : '0);
    next_y      = cur_y_q + (move_y ? step_y : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else if (in_accept) begin
      if (opcode_i == OP_BEGIN) begin
        remain_q <= span_major;
      end else if (line_active) begin
        remain_q <= remain_q - C'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (opcode_i == OP_BEGIN) begin
        cur_x_q     <= start_x_i;
        cur_y_q     <= start_y_i;
        x_neg_q     <= dx[C];
        y_neg_q     <= dy[C];
        y_major_q   <= begin_y_major;
        two_minor_q <= {span_minor, 1'b0};
        two_major_q <= {span_major, 1'b0};
        err_q       <= -$signed(EW'(span_major));
        color_q     <= line_color_i;
      end else if (line_active) begin
        cur_x_q <= next_x;
        cur_y_q <= next_y;
        err_q   <= err_next;
      end
    end
  end

  // Stage one result register.
  logic                s1_idle_q, s1_last_q;
  logic signed [C-1:0] s1_x_q, s1_y_q;
  logic [COLOR_BITS-1:0] s1_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (opcode_i == OP_BEGIN) begin
        s1_idle_q  <= 1'b0;
        s1_x_q     <= start_x_i;
        s1_y_q     <= start_y_i;
        s1_color_q <= line_color_i;
        s1_last_q  <= span_major == '0;
      end else if (line_active) begin
        s1_idle_q  <= 1'b0;
        s1_x_q     <= next_x;
        s1_y_q     <= next_y;
        s1_color_q <= color_q;
        s1_last_q  <= remain_q == C'(1);
      end else begin
        s1_idle_q  <= 1'b1;
        s1_x_q     <= '0;
        s1_y_q     <= '0;
        s1_color_q <= '0;
        s1_last_q  <= 1'b1;
      end
    end
  end

  // Stage two: clipping and address.
  logic            in_frame;
  logic [2*C-1:0]  row_base;
  logic [AW-1:0]   address;

  always_comb begin
    in_frame = !s1_idle_q && !s1_x_q[C-1] && !s1_y_q[C-1] &&
               (s1_x_q < frame_width_q) && (s1_y_q < frame_height_q);
    row_base = s1_y_q * frame_width_q;
    address  = in_frame ? row_base[AW-1:0] + AW'(s1_x_q) : '0;
  end

  logic                out_we_q, out_last_q;
  logic signed [C-1:0] out_x_q, out_y_q;
  logic [AW-1:0]       out_addr_q;
  logic [COLOR_BITS-1:0] out_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      out_we_q    <= in_frame;
      out_x_q     <= s1_x_q;
      out_y_q     <= s1_y_q;
      out_addr_q  <= address;
      out_color_q <= s1_color_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = out_we_q;
  assign pixel_x_o       = out_x_q;
  assign pixel_y_o       = out_y_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_color_o   = out_color_q;
  assign last_o          = out_last_q;

endmodule
